>>> rtl/pfa_pkg.sv
// Paged frame allocator: shared types, codes and constants.
// Used by pfa_front, pfa_back and paged_frame_allocator.
package pfa_pkg;

	localparam int unsigned NUM_FRAMES_DEF = 64;
	localparam int unsigned PAGE_UNITS_DEF = 4;
	localparam int unsigned PROCESSES_DEF  = 16;

	localparam int unsigned CNT_W    = 7;   // page and frame counts
	localparam int unsigned NEED_MAX = 127;
	localparam int unsigned RECIP_SH = 18;  // reciprocal scaling for size/PAGE_UNITS

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;
	localparam logic MODE_ALL = 1'b0;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_MIN  = 3'd4;
	localparam logic [6:0] MIN_RESET = 7'd4;

	typedef struct packed {
		logic       op;
		logic       p_ok;
		logic [3:0] proc_id;
		logic [8:0] size;
		logic       done_req;
	} cmd_t;

	typedef struct packed {
		logic       strobe;
		logic [1:0] kind;
		logic [6:0] value;
		logic       can_run;
		logic       last;
	} res_t;

	typedef enum logic [3:0] {
		B_IDLE, B_MUL, B_DEC, B_ADROP_RD, B_ADROP_WR, B_FILL, B_FDROP_RD, B_FDROP_WR
	} back_state_t;

endpackage

>>> rtl/pfa_front.sv
// Front end: takes commands, checks the process index, queues them (two deep).
// Depends on pfa_pkg.
module pfa_front #(
	parameter int unsigned PROCESSES = pfa_pkg::PROCESSES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             operation,
	input  logic [3:0]       process,
	input  logic [8:0]       req_size,
	input  logic             done_req,
	output logic             q_valid,
	output pfa_pkg::cmd_t    q_head,
	input  logic             q_pop
);
	pfa_pkg::cmd_t fifo_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	pfa_pkg::cmd_t cmd_in;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = fifo_q[rp_q];

	always_comb begin
		cmd_in.op       = operation;
		cmd_in.p_ok     = (9'(process) < 9'(PROCESSES));
		cmd_in.proc_id  = process;
		cmd_in.size     = req_size;
		cmd_in.done_req = done_req;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty command queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("command queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count missed a push");

endmodule

>>> rtl/pfa_back.sv
// Back end: frame bitmap, per-process page ranges, page memory and the
// allocate / free sequencer. Depends on pfa_pkg.
module pfa_back #(
	parameter int unsigned NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
	parameter int unsigned PAGE_UNITS = pfa_pkg::PAGE_UNITS_DEF,
	parameter int unsigned PROCESSES  = pfa_pkg::PROCESSES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  pfa_pkg::cmd_t q_head,
	output logic          q_pop,
	input  logic          mode,
	input  logic [6:0]    floor_pages,
	output pfa_pkg::res_t res
);
	localparam int unsigned FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int unsigned PW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int unsigned DEPTH = PROCESSES << FW;
	localparam int unsigned RECIP = ((1 << pfa_pkg::RECIP_SH) + PAGE_UNITS - 1) / PAGE_UNITS;
	localparam int unsigned CW    = pfa_pkg::CNT_W;

	pfa_pkg::back_state_t st_q, st_d;

	logic [FW-1:0]     pg_mem [DEPTH];
	logic [FW-1:0]     rd_q;
	logic [PW+FW-1:0]  raddr, waddr;
	logic              we;

	logic [CW-1:0] lo_a [PROCESSES];
	logic [CW-1:0] hi_a [PROCESSES];
	logic [CW-1:0] nd_a [PROCESSES];
	logic          tb_a [PROCESSES];

	pfa_pkg::cmd_t     cmd_q;
	logic [CW-1:0]     lo_w, hi_w, nd_w, take_q, i_q, free_q;
	logic              tbl_w, all_q;
	logic [FW-1:0]     f_q;
	logic [NUM_FRAMES-1:0] busy_q;
	logic [28:0]       prod_q;
	logic [PW-1:0]     ph, pc;
	pfa_pkg::res_t     res_d;

	logic [10:0]       need_full;
	logic [CW-1:0]     needed, avail, held, take_c;
	logic              ok_c, run_old, last_c, evict_all, none_free;

	assign ph     = q_head.p_ok ? PW'(q_head.proc_id) : '0;
	assign pc     = PW'(cmd_q.proc_id);
	assign q_pop  = (st_q == pfa_pkg::B_IDLE) && q_valid;
	assign raddr  = {pc, i_q[FW-1:0]};
	assign waddr  = {pc, i_q[FW-1:0]};
	assign we     = (st_q == pfa_pkg::B_FILL) && (i_q != take_q) && !busy_q[f_q];

	assign held      = hi_w - lo_w;
	assign need_full = prod_q[28:pfa_pkg::RECIP_SH];
	assign needed    = (need_full > 11'(pfa_pkg::NEED_MAX)) ? CW'(pfa_pkg::NEED_MAX)
		: need_full[CW-1:0];
	assign avail     = free_q + (tbl_w ? held : '0);
	assign run_old   = tbl_w && ((mode == pfa_pkg::MODE_ALL) || held >= nd_w
		|| held >= floor_pages);
	assign evict_all = (mode == pfa_pkg::MODE_ALL) || q_head.done_req;
	assign none_free = (tb_a[ph] == 1'b0) || (lo_a[ph] == hi_a[ph])
		|| (!evict_all && free_q >= floor_pages);
	assign last_c    = (i_q + 1'b1 == hi_w) || (!all_q && (free_q + 1'b1 >= floor_pages));

	always_comb begin
		if (mode == pfa_pkg::MODE_ALL) begin
			ok_c   = needed <= avail;
			take_c = needed;
		end else begin
			ok_c   = avail >= floor_pages;
			take_c = (needed < avail) ? needed : avail;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pfa_pkg::B_IDLE: begin
				if (q_valid && q_head.p_ok) begin
					if (q_head.op == pfa_pkg::OP_ALLOC) st_d = pfa_pkg::B_MUL;
					else if (!none_free) st_d = pfa_pkg::B_FDROP_RD;
				end
			end
			pfa_pkg::B_MUL: st_d = pfa_pkg::B_DEC;
			pfa_pkg::B_DEC: begin
				if (!ok_c) st_d = pfa_pkg::B_IDLE;
				else if (tbl_w && lo_w != hi_w) st_d = pfa_pkg::B_ADROP_RD;
				else st_d = pfa_pkg::B_FILL;
			end
			pfa_pkg::B_ADROP_RD: st_d = pfa_pkg::B_ADROP_WR;
			pfa_pkg::B_ADROP_WR: st_d = (i_q + 1'b1 == hi_w) ? pfa_pkg::B_FILL
				: pfa_pkg::B_ADROP_RD;
			pfa_pkg::B_FILL: if (i_q == take_q) st_d = pfa_pkg::B_IDLE;
			pfa_pkg::B_FDROP_RD: st_d = pfa_pkg::B_FDROP_WR;
			pfa_pkg::B_FDROP_WR: st_d = last_c ? pfa_pkg::B_IDLE : pfa_pkg::B_FDROP_RD;
			default: st_d = pfa_pkg::B_IDLE;
		endcase
	end

	// result beat for the coming cycle
	always_comb begin
		res_d = '0;
		unique case (st_q)
			pfa_pkg::B_IDLE: begin
				if (q_valid) begin
					if (!q_head.p_ok) begin
						res_d = '{1'b1, (q_head.op == pfa_pkg::OP_ALLOC) ? pfa_pkg::KIND_ALLOC
							: pfa_pkg::KIND_NONE, 7'd0, 1'b0, 1'b1};
					end else if (q_head.op == pfa_pkg::OP_FREE && none_free) begin
						res_d = '{1'b1, pfa_pkg::KIND_NONE, 7'd0, 1'b0, 1'b1};
					end
				end
			end
			pfa_pkg::B_DEC: begin
				if (!ok_c) res_d = '{1'b1, pfa_pkg::KIND_ALLOC, 7'd0, run_old, 1'b1};
			end
			pfa_pkg::B_FILL: begin
				if (i_q == take_q) begin
					res_d = '{1'b1, pfa_pkg::KIND_ALLOC, take_q,
						(mode == pfa_pkg::MODE_ALL) || take_q >= nd_w
						|| take_q >= floor_pages, 1'b1};
				end
			end
			pfa_pkg::B_FDROP_WR: res_d = '{1'b1, pfa_pkg::KIND_FRAME, 7'(rd_q), 1'b0, last_c};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) pg_mem[waddr] <= f_q;
		rd_q <= pg_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= pfa_pkg::B_IDLE;
			busy_q <= '0;
			free_q <= CW'(NUM_FRAMES);
			res    <= '0;
			for (int k = 0; k < PROCESSES; k++) begin
				lo_a[k] <= '0;
				hi_a[k] <= '0;
				nd_a[k] <= '0;
				tb_a[k] <= 1'b0;
			end
		end else begin
			st_q <= st_d;
			res  <= res_d;
			unique case (st_q)
				pfa_pkg::B_IDLE: begin
					if (q_valid && q_head.p_ok && q_head.op == pfa_pkg::OP_FREE && none_free
							&& tb_a[ph] && evict_all) begin
						tb_a[ph] <= 1'b0;
						lo_a[ph] <= '0;
						hi_a[ph] <= '0;
						nd_a[ph] <= '0;
					end
				end
				pfa_pkg::B_ADROP_WR: begin
					busy_q[rd_q] <= 1'b0;
					free_q       <= free_q + 1'b1;
				end
				pfa_pkg::B_FILL: begin
					if (i_q == take_q) begin
						lo_a[pc] <= '0;
						hi_a[pc] <= take_q;
						nd_a[pc] <= nd_w;
						tb_a[pc] <= 1'b1;
					end else if (!busy_q[f_q]) begin
						busy_q[f_q] <= 1'b1;
						free_q      <= free_q - 1'b1;
					end
				end
				pfa_pkg::B_FDROP_WR: begin
					busy_q[rd_q] <= 1'b0;
					free_q       <= free_q + 1'b1;
					lo_a[pc]     <= (last_c && all_q) ? '0 : i_q + 1'b1;
					if (last_c && all_q) begin
						tb_a[pc] <= 1'b0;
						hi_a[pc] <= '0;
						nd_a[pc] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// working copies and counters
	always_ff @(posedge clk) begin
		unique case (st_q)
			pfa_pkg::B_IDLE: begin
				cmd_q  <= q_head;
				lo_w   <= lo_a[ph];
				hi_w   <= hi_a[ph];
				nd_w   <= nd_a[ph];
				tbl_w  <= tb_a[ph];
				all_q  <= evict_all;
				i_q    <= lo_a[ph];
				prod_q <= 29'(10'(q_head.size) + 10'(PAGE_UNITS - 1)) * 29'(RECIP);
			end
			pfa_pkg::B_DEC: begin
				nd_w   <= needed;
				take_q <= take_c;
				f_q    <= '0;
				if (!(tbl_w && lo_w != hi_w)) i_q <= '0;
			end
			pfa_pkg::B_ADROP_WR: i_q <= (i_q + 1'b1 == hi_w) ? '0 : i_q + 1'b1;
			pfa_pkg::B_FILL: begin
				if (i_q != take_q) begin
					f_q <= f_q + 1'b1;
					if (!busy_q[f_q]) i_q <= i_q + 1'b1;
				end
			end
			pfa_pkg::B_FDROP_WR: i_q <= i_q + 1'b1;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(busy_q)) + 32'(free_q) == 32'(NUM_FRAMES))
		else $error("bitmap and free count disagree");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.strobe && res.kind != pfa_pkg::KIND_ALLOC) |-> !res.can_run)
		else $error("can_run set on a free result");
	assert property (@(posedge clk) disable iff (!arst_n)
		we |=> (free_q == $past(free_q) - 1'b1))
		else $error("frame fill did not take a free frame");

endmodule

>>> rtl/paged_frame_allocator.sv
// A granted alloc first drops the frames that its process still holds, then scans the bitmap
// for free frames; a free gives one frame beat per frame it drops, the last flagged by last.
// One command runs at a time in the back sequencer; a two-deep queue takes starts ahead.
// Results cannot be stalled. Reset (arst_n low) frees every frame, clears all tables,
// mode 0, page floor 4; no clearing pass is needed.
module paged_frame_allocator #(
	parameter int unsigned NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
	parameter int unsigned PAGE_UNITS = pfa_pkg::PAGE_UNITS_DEF,
	parameter int unsigned PROCESSES  = pfa_pkg::PROCESSES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [3:0]  process,
	input  logic [8:0]  req_size,
	input  logic        done_req,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [6:0]  value,
	output logic        can_run,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic          mode_q;
	logic [6:0]    min_q;
	logic          q_valid, q_pop;
	pfa_pkg::cmd_t q_head;
	pfa_pkg::res_t res;

	assign pready = 1'b1;
	assign prdata = (paddr == pfa_pkg::REG_MODE) ? {31'd0, mode_q}
		: (paddr == pfa_pkg::REG_MIN) ? {25'd0, min_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pfa_pkg::MODE_ALL;
			min_q  <= pfa_pkg::MIN_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr == pfa_pkg::REG_MODE) mode_q <= pwdata[0];
			if (paddr == pfa_pkg::REG_MIN)  min_q  <= pwdata[6:0];
		end
	end

	pfa_front #(.PROCESSES(PROCESSES)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .process(process), .req_size(req_size), .done_req(done_req),
		.q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
	);

	pfa_back #(.NUM_FRAMES(NUM_FRAMES), .PAGE_UNITS(PAGE_UNITS), .PROCESSES(PROCESSES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
		.mode(mode_q), .floor_pages(min_q), .res(res)
	);

	assign strobe  = res.strobe;
	assign kind    = res.kind;
	assign value   = res.value;
	assign can_run = res.can_run;
	assign last    = res.last;

endmodule

>>> sim/paged_frame_allocator_tb.sv
// Self-checking testbench for paged_frame_allocator: directed and random commands
// with an internal frame/page-table predictor. Depends on rtl/pfa_pkg.sv and the RTL.
`timescale 1ns / 1ps

module paged_frame_allocator_tb;

	localparam int NFRAMES = 64;
	localparam int FSIZE   = 4;
	localparam int NPROC   = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [2:0] ADDR_MODE = pfa_pkg::REG_MODE;
	localparam logic [2:0] ADDR_MIN  = pfa_pkg::REG_MIN;
	localparam logic MODE_VIRT = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] value;
		logic       can_run;
		logic       last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = 1'b0;
	logic [3:0]  process = '0;
	logic [8:0]  req_size = '0;
	logic        done_req = 1'b0;
	logic        strobe;
	logic [1:0]  kind;
	logic [6:0]  value;
	logic        can_run;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	paged_frame_allocator dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	bit         frame_used[NFRAMES];
	int         free_cnt;
	logic [6:0] page_map[NPROC][NFRAMES];   // bit 6 valid, 5:0 frame
	int         need_cnt[NPROC];
	int         held_cnt[NPROC];
	bit         owns_table[NPROC];
	logic       cfg_mode;
	int         cfg_min;

	beat_t expected_beats[$];
	int    err_cnt = 0;
	int    burst_left = 0;
	longint cycle_cnt = 0;

	function automatic bit drop_entry(int p, int i, output int f);
		if (!page_map[p][i][6]) return 0;
		f = page_map[p][i][5:0];
		page_map[p][i] = '0;
		if (frame_used[f]) begin
			frame_used[f] = 0;
			free_cnt++;
		end
		if (held_cnt[p] > 0) held_cnt[p]--;
		return 1;
	endfunction

	function automatic logic runnable(int p);
		if (!owns_table[p]) return 1'b0;
		if (cfg_mode == pfa_pkg::MODE_ALL) return 1'b1;
		return (held_cnt[p] >= need_cnt[p] || held_cnt[p] >= cfg_min);
	endfunction

	function automatic void predict_alloc(int p, int size);
		int need, avail, take, f, i, dummy;
		bit ok;
		beat_t b;
		need = (size + FSIZE - 1) / FSIZE;
		avail = free_cnt + (owns_table[p] ? held_cnt[p] : 0);
		if (need > int'(pfa_pkg::NEED_MAX)) need = int'(pfa_pkg::NEED_MAX);
		if (cfg_mode == pfa_pkg::MODE_ALL) begin
			ok = need <= avail;
			take = need;
		end else begin
			ok = avail >= cfg_min;
			take = need < avail ? need : avail;
		end
		if (ok) begin
			for (i = 0; i < NFRAMES; i++) void'(drop_entry(p, i, dummy));
			held_cnt[p] = 0;
			need_cnt[p] = need;
			owns_table[p] = 1;
			f = 0;
			for (i = 0; i < take && i < NFRAMES; i++) begin
				while (f < NFRAMES && frame_used[f]) f++;
				if (f >= NFRAMES) break;
				frame_used[f] = 1;
				free_cnt--;
				page_map[p][i] = {1'b1, 6'(f)};
				held_cnt[p]++;
			end
		end
		b.kind = pfa_pkg::KIND_ALLOC;
		b.value = ok ? 7'(take) : 7'd0;
		b.can_run = runnable(p);
		b.last = 1'b1;
		expected_beats.push_back(b);
	endfunction

	function automatic void predict_free(int p, bit done);
		beat_t freed[$];
		beat_t b;
		int i, f, lim;
		b = '{kind: pfa_pkg::KIND_FRAME, value: '0, can_run: 1'b0, last: 1'b0};
		if (owns_table[p]) begin
			if (cfg_mode == pfa_pkg::MODE_ALL || done) begin
				for (i = 0; i < NFRAMES; i++)
					if (drop_entry(p, i, f)) begin
						b.value = 7'(f);
						freed.push_back(b);
					end
				owns_table[p] = 0;
				held_cnt[p] = 0;
				need_cnt[p] = 0;
			end else begin
				lim = need_cnt[p] < NFRAMES ? need_cnt[p] : NFRAMES;
				for (i = 0; i < lim && free_cnt < cfg_min; i++)
					if (drop_entry(p, i, f)) begin
						b.value = 7'(f);
						freed.push_back(b);
					end
			end
		end
		if (freed.size() == 0) begin
			b = '{kind: pfa_pkg::KIND_NONE, value: '0, can_run: 1'b0, last: 1'b1};
			freed.push_back(b);
		end
		freed[freed.size()-1].last = 1'b1;
		foreach (freed[k]) expected_beats.push_back(freed[k]);
	endfunction

	// one command beat, sent in bursts with random gaps
	task automatic send_cmd(logic op, int p, int size, bit done);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		operation <= op;
		process <= 4'(p);
		req_size <= 9'(size);
		done_req <= done;
		do @(posedge clk); while (busy);
		if (op == pfa_pkg::OP_ALLOC) predict_alloc(p, size);
		else predict_free(p, done);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		burst_left = 0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] a, int d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= 32'(d);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == ADDR_MODE) cfg_mode = d[0];
		else cfg_min = d & 7'h7f;
	endtask

	task automatic set_config(logic m, int mp);
		wait_idle();
		apb_write(ADDR_MODE, m);
		apb_write(ADDR_MIN, mp);
	endtask

	task automatic test_paging_directed();
		send_cmd(pfa_pkg::OP_FREE, 3, 0, 0);      // no table
		send_cmd(pfa_pkg::OP_ALLOC, 0, 0, 0);     // empty request
		send_cmd(pfa_pkg::OP_ALLOC, 1, 256, 0);   // all 64 frames
		send_cmd(pfa_pkg::OP_ALLOC, 2, 1, 0);     // no room
		send_cmd(pfa_pkg::OP_ALLOC, 1, 9, 0);     // realloc, old frames count
		send_cmd(pfa_pkg::OP_ALLOC, 2, 511, 0);   // saturated need, fails
		send_cmd(pfa_pkg::OP_ALLOC, 2, 5, 0);
		send_cmd(pfa_pkg::OP_FREE, 1, 0, 1);
		send_cmd(pfa_pkg::OP_FREE, 0, 0, 0);      // empty table, nothing freed
		send_cmd(pfa_pkg::OP_FREE, 2, 0, 0);
		send_cmd(pfa_pkg::OP_ALLOC, 15, 255, 0);
		send_cmd(pfa_pkg::OP_FREE, 15, 0, 0);
	endtask

	task automatic test_virtual_directed();
		set_config(MODE_VIRT, 4);
		send_cmd(pfa_pkg::OP_ALLOC, 4, 200, 0);   // 50 pages
		send_cmd(pfa_pkg::OP_ALLOC, 5, 511, 0);   // partial, 14 frames
		send_cmd(pfa_pkg::OP_ALLOC, 6, 8, 0);     // below the page floor
		send_cmd(pfa_pkg::OP_FREE, 4, 0, 0);      // evict lowest pages
		send_cmd(pfa_pkg::OP_FREE, 4, 0, 0);      // target met, nothing evicted
		send_cmd(pfa_pkg::OP_FREE, 5, 0, 1);
		set_config(MODE_VIRT, 64);
		send_cmd(pfa_pkg::OP_ALLOC, 7, 16, 0);    // page floor too large
		send_cmd(pfa_pkg::OP_FREE, 4, 0, 0);      // drops all held, keeps table
		send_cmd(pfa_pkg::OP_ALLOC, 4, 4, 0);
		set_config(pfa_pkg::MODE_ALL, 1);
		send_cmd(pfa_pkg::OP_FREE, 4, 0, 0);      // table from virtual mode
	endtask

	task automatic test_random(logic m, int mp, int count);
		int r, size;
		set_config(m, mp);
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 80) size = $urandom_range(0, 48);
			else if (r < 96) size = $urandom_range(0, 256);
			else size = $urandom_range(257, 511);
			send_cmd(logic'($urandom_range(0, 1)), $urandom_range(0, NPROC-1), size,
				($urandom_range(0, 3) == 0));
		end
	endtask

	always @(posedge clk) begin
		beat_t e;
		if (strobe) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat kind=%0d value=%0d can_run=%0d last=%0d",
					$time, kind, value, can_run, last);
				err_cnt++;
			end else begin
				e = expected_beats.pop_front();
				if (kind !== e.kind || value !== e.value || can_run !== e.can_run ||
						last !== e.last) begin
					$display("%0t: mismatch exp kind=%0d value=%0d can_run=%0d last=%0d,",
						$time, e.kind, e.value, e.can_run, e.last);
					$display("%0t:          got kind=%0d value=%0d can_run=%0d last=%0d",
						$time, kind, value, can_run, last);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("paged_frame_allocator_tb: errors");
			$finish;
		end
	end

	initial begin
		foreach (frame_used[i]) frame_used[i] = 0;
		foreach (page_map[p, i]) page_map[p][i] = '0;
		foreach (need_cnt[p]) begin
			need_cnt[p] = 0;
			held_cnt[p] = 0;
			owns_table[p] = 0;
		end
		free_cnt = NFRAMES;
		cfg_mode = pfa_pkg::MODE_ALL;
		cfg_min = pfa_pkg::MIN_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_paging_directed();
		test_virtual_directed();
		test_random(pfa_pkg::MODE_ALL, 4, 90);
		test_random(MODE_VIRT, 1, 90);
		test_random(MODE_VIRT, 64, 60);
		test_random(MODE_VIRT, $urandom_range(2, 63), 120);
		test_random(pfa_pkg::MODE_ALL, 64, 90);
		wait_idle();
		if (err_cnt == 0)
			$display("paged_frame_allocator_tb: clean");
		else
			$display("paged_frame_allocator_tb: errors");
		$finish;
	end

endmodule

>>> sim.f
rtl/pfa_pkg.sv
rtl/pfa_front.sv
rtl/pfa_back.sv
rtl/paged_frame_allocator.sv
sim/paged_frame_allocator_tb.sv
